// File: rtl/core/sit_pkg.sv
package sit_pkg;

   // two lanes run side by side through the divider: x offset and y offset
   localparam int unsigned LANES  = 2;
   localparam int unsigned LANE_X = 0;
   localparam int unsigned LANE_Y = 1;

   // per transaction flags carried down the divider pipeline
   typedef struct packed {
      logic hit;
      logic neg_x;
      logic neg_y;
   } sit_flags_type;

endpackage

// File: rtl/core/segment_intersection_test_core.sv
// channel   direction  ports                                         handshake
// req       in         req_ax req_ay req_bx req_by_coord req_cx      req_valid/req_ready
//                      req_cy req_dx req_dy
// rsp       out        rsp_hit rsp_cross_x rsp_cross_y               rsp_valid/rsp_ready
//
// one transaction enters per cycle unless a stalled rsp has filled every stage
// four front stages (differences, products, cross terms, range test), then one
// divider stage per bit of dmag (COORD_WIDTH + 1), then the output register
// each stage holds its own valid bit; a stalled rsp only backs up full stages,
// so bubbles are squeezed out and req_ready stays high while any stage is empty
// reset is synchronous and clears the valid bits only
module segment_intersection_test_core #(
   parameter int unsigned COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_ax,
   input  logic signed [COORD_WIDTH-1:0] req_ay,
   input  logic signed [COORD_WIDTH-1:0] req_bx,
   input  logic signed [COORD_WIDTH-1:0] req_by_coord,
   input  logic signed [COORD_WIDTH-1:0] req_cx,
   input  logic signed [COORD_WIDTH-1:0] req_cy,
   input  logic signed [COORD_WIDTH-1:0] req_dx,
   input  logic signed [COORD_WIDTH-1:0] req_dy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_y
);
   import sit_pkg::*;

   localparam int unsigned DW     = COORD_WIDTH + 1;  // coordinate difference
   localparam int unsigned PW     = 2 * DW;           // product
   localparam int unsigned NW     = PW + 1;           // den, na, nb
   localparam int unsigned MW     = NW - 1;           // magnitudes in the divider
   localparam int unsigned FRONT  = 4;
   localparam int unsigned STAGES = FRONT + DW + 1;

   logic [STAGES-1:0] stage_valid_ff;
   logic [STAGES-1:0] stage_valid_in;
   logic [STAGES:0]   rdy;

   // stage 0: differences
   logic signed [DW-1:0]           s0_d12x_ff, s0_d12y_ff, s0_d34x_ff, s0_d34y_ff;
   logic signed [DW-1:0]           s0_d42x_ff, s0_d42y_ff;
   logic [LANES-1:0][COORD_WIDTH-1:0] s0_base_ff;

   // stage 1: products
   logic signed [PW-1:0]           s1_den_a_ff, s1_den_b_ff, s1_na_a_ff, s1_na_b_ff;
   logic signed [PW-1:0]           s1_nb_a_ff, s1_nb_b_ff;
   logic signed [DW-1:0]           s1_d12x_ff, s1_d12y_ff;
   logic [LANES-1:0][COORD_WIDTH-1:0] s1_base_ff;

   // stage 2: cross terms
   logic signed [NW-1:0]           s2_den_ff, s2_na_ff, s2_nb_ff;
   logic signed [DW-1:0]           s2_d12x_ff, s2_d12y_ff;
   logic [LANES-1:0][COORD_WIDTH-1:0] s2_base_ff;

   // stage 3: range test and magnitudes
   logic                           den_pos;
   logic                           hit_pos;
   logic                           hit_neg;
   sit_flags_type                  s3_flags_in, s3_flags_ff;
   logic signed [NW-1:0]           s3_den_neg, s3_na_neg;
   logic [MW-1:0]                  s3_den_in, s3_den_ff;
   logic [MW-1:0]                  s3_na_in, s3_na_ff;
   logic signed [DW-1:0]           s3_d12x_neg, s3_d12y_neg;
   logic [LANES-1:0][DW-1:0]       s3_dmag_in, s3_dmag_ff;
   logic [LANES-1:0][COORD_WIDTH-1:0] s3_base_ff;

   // divider chain
   sit_flags_type                     ch_flags [DW+1];
   logic [MW-1:0]                     ch_den   [DW+1];
   logic [MW-1:0]                     ch_na    [DW+1];
   logic [LANES-1:0][DW-1:0]          ch_dmag  [DW+1];
   logic [LANES-1:0][MW-1:0]          ch_rem   [DW+1];
   logic [LANES-1:0][DW-1:0]          ch_q     [DW+1];
   logic [LANES-1:0][COORD_WIDTH-1:0] ch_base  [DW+1];

   // output stage
   logic signed [DW:0]                lane_ofs [LANES];
   logic signed [DW:0]                lane_sum [LANES];
   logic                              out_hit_in, out_hit_ff;
   logic signed [COORD_WIDTH-1:0]     out_x_in, out_x_ff;
   logic signed [COORD_WIDTH-1:0]     out_y_in, out_y_ff;

   // a stage takes new data when it is empty or its content moves on
   assign rdy[STAGES] = rsp_ready;
   for (genvar k = 0; k < STAGES; k++) begin : g_rdy
      assign rdy[k] = !stage_valid_ff[k] || rdy[k+1];
   end

   assign stage_valid_in = {stage_valid_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
               stage_valid_ff[k] <= stage_valid_in[k];
            end
         end
      end
   end

   assign req_ready = rdy[0] && !reset;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s0_d12x_ff <= DW'(req_ax) - DW'(req_bx);
         s0_d12y_ff <= DW'(req_ay) - DW'(req_by_coord);
         s0_d34x_ff <= DW'(req_dx) - DW'(req_cx);
         s0_d34y_ff <= DW'(req_dy) - DW'(req_cy);
         s0_d42x_ff <= DW'(req_dx) - DW'(req_bx);
         s0_d42y_ff <= DW'(req_dy) - DW'(req_by_coord);
         s0_base_ff[LANE_X] <= req_bx;
         s0_base_ff[LANE_Y] <= req_by_coord;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_den_a_ff <= PW'(s0_d34y_ff) * PW'(s0_d12x_ff);
         s1_den_b_ff <= PW'(s0_d34x_ff) * PW'(s0_d12y_ff);
         s1_na_a_ff  <= PW'(s0_d42x_ff) * PW'(s0_d34y_ff);
         s1_na_b_ff  <= PW'(s0_d34x_ff) * PW'(s0_d42y_ff);
         s1_nb_a_ff  <= PW'(s0_d12x_ff) * PW'(s0_d42y_ff);
         s1_nb_b_ff  <= PW'(s0_d42x_ff) * PW'(s0_d12y_ff);
         s1_d12x_ff  <= s0_d12x_ff;
         s1_d12y_ff  <= s0_d12y_ff;
         s1_base_ff  <= s0_base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_den_ff  <= NW'(s1_den_a_ff) - NW'(s1_den_b_ff);
         s2_na_ff   <= NW'(s1_na_a_ff) - NW'(s1_na_b_ff);
         s2_nb_ff   <= NW'(s1_nb_a_ff) - NW'(s1_nb_b_ff);
         s2_d12x_ff <= s1_d12x_ff;
         s2_d12y_ff <= s1_d12y_ff;
         s2_base_ff <= s1_base_ff;
      end
   end

   // both parameters in [0,1]: numerators share the sign of den and do not exceed it
   always_comb begin
      den_pos = !s2_den_ff[NW-1];
      hit_pos = !s2_na_ff[NW-1] && (s2_na_ff <= s2_den_ff)
             && !s2_nb_ff[NW-1] && (s2_nb_ff <= s2_den_ff);
      hit_neg = (s2_na_ff <= 0) && (s2_na_ff >= s2_den_ff)
             && (s2_nb_ff <= 0) && (s2_nb_ff >= s2_den_ff);
      s3_flags_in.hit   = (s2_den_ff != '0) && (den_pos ? hit_pos : hit_neg);
      s3_flags_in.neg_x = s2_d12x_ff[DW-1];
      s3_flags_in.neg_y = s2_d12y_ff[DW-1];
      s3_den_neg  = -s2_den_ff;
      s3_na_neg   = -s2_na_ff;
      s3_den_in   = den_pos ? s2_den_ff[MW-1:0] : s3_den_neg[MW-1:0];
      s3_na_in    = den_pos ? s2_na_ff[MW-1:0] : s3_na_neg[MW-1:0];
      s3_d12x_neg = -s2_d12x_ff;
      s3_d12y_neg = -s2_d12y_ff;
      s3_dmag_in[LANE_X] = s2_d12x_ff[DW-1] ? s3_d12x_neg : s2_d12x_ff;
      s3_dmag_in[LANE_Y] = s2_d12y_ff[DW-1] ? s3_d12y_neg : s2_d12y_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_flags_ff <= s3_flags_in;
         s3_den_ff   <= s3_den_in;
         s3_na_ff    <= s3_na_in;
         s3_dmag_ff  <= s3_dmag_in;
         s3_base_ff  <= s2_base_ff;
      end
   end

   assign ch_flags[0] = s3_flags_ff;
   assign ch_den[0]   = s3_den_ff;
   assign ch_na[0]    = s3_na_ff;
   assign ch_dmag[0]  = s3_dmag_ff;
   assign ch_rem[0]   = '0;
   assign ch_q[0]     = '0;
   assign ch_base[0]  = s3_base_ff;

   for (genvar k = 0; k < DW; k++) begin : g_div
      sit_div_step #(
         .DIG_WIDTH  (DW),
         .REM_WIDTH  (MW),
         .BASE_WIDTH (COORD_WIDTH),
         .STEP       (k)
      ) u_step (
         .clock    (clock),
         .load     (rdy[FRONT+k]),
         .up_flags (ch_flags[k]),
         .up_den   (ch_den[k]),
         .up_na    (ch_na[k]),
         .up_dmag  (ch_dmag[k]),
         .up_rem   (ch_rem[k]),
         .up_q     (ch_q[k]),
         .up_base  (ch_base[k]),
         .dn_flags (ch_flags[k+1]),
         .dn_den   (ch_den[k+1]),
         .dn_na    (ch_na[k+1]),
         .dn_dmag  (ch_dmag[k+1]),
         .dn_rem   (ch_rem[k+1]),
         .dn_q     (ch_q[k+1]),
         .dn_base  (ch_base[k+1])
      );
   end

   // crossing point: P2 plus the signed offset, truncated toward zero; zero when there is no hit
   always_comb begin
      lane_ofs[LANE_X] = ch_flags[DW].neg_x ? -$signed({1'b0, ch_q[DW][LANE_X]})
                                            :  $signed({1'b0, ch_q[DW][LANE_X]});
      lane_ofs[LANE_Y] = ch_flags[DW].neg_y ? -$signed({1'b0, ch_q[DW][LANE_Y]})
                                            :  $signed({1'b0, ch_q[DW][LANE_Y]});
      for (int l = 0; l < LANES; l++) begin
         lane_sum[l] = (DW+1)'($signed(ch_base[DW][l])) + lane_ofs[l];
      end
      out_hit_in = ch_flags[DW].hit;
      out_x_in   = out_hit_in ? lane_sum[LANE_X][COORD_WIDTH-1:0] : '0;
      out_y_in   = out_hit_in ? lane_sum[LANE_Y][COORD_WIDTH-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (rdy[STAGES-1]) begin
         out_hit_ff <= out_hit_in;
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
      end
   end

   assign rsp_valid   = stage_valid_ff[STAGES-1];
   assign rsp_hit     = out_hit_ff;
   assign rsp_cross_x = out_x_ff;
   assign rsp_cross_y = out_y_ff;

   // input only stalls when every stage holds a transaction
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !rdy[0] |-> (&stage_valid_ff))
      else $error("input stalled with an empty pipeline stage");

   // a hit always has a nonzero den and na within it
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff[FRONT-1] && s3_flags_ff.hit)
         |-> (s3_den_ff != '0) && (s3_na_ff <= s3_den_ff))
      else $error("hit flagged with na outside [0,den]");

   // divider remainder stays below den on a hit
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff[FRONT+DW-1] && ch_flags[DW].hit)
         |-> (ch_rem[DW][LANE_X] < ch_den[DW]) && (ch_rem[DW][LANE_Y] < ch_den[DW]))
      else $error("divider remainder out of range");

   // no hit gives a zero point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_cross_x == '0) && (rsp_cross_y == '0))
      else $error("nonzero point without a hit");

endmodule

// File: rtl/core/sit_div_step.sv
module sit_div_step #(
   parameter int unsigned DIG_WIDTH  = 17,
   parameter int unsigned REM_WIDTH  = 34,
   parameter int unsigned BASE_WIDTH = 16,
   parameter int unsigned STEP       = 0
) (
   input  logic                                               clock,
   input  logic                                               load,
   input  sit_pkg::sit_flags_type                             up_flags,
   input  logic [REM_WIDTH-1:0]                               up_den,
   input  logic [REM_WIDTH-1:0]                               up_na,
   input  logic [sit_pkg::LANES-1:0][DIG_WIDTH-1:0]           up_dmag,
   input  logic [sit_pkg::LANES-1:0][REM_WIDTH-1:0]           up_rem,
   input  logic [sit_pkg::LANES-1:0][DIG_WIDTH-1:0]           up_q,
   input  logic [sit_pkg::LANES-1:0][BASE_WIDTH-1:0]          up_base,
   output sit_pkg::sit_flags_type                             dn_flags,
   output logic [REM_WIDTH-1:0]                               dn_den,
   output logic [REM_WIDTH-1:0]                               dn_na,
   output logic [sit_pkg::LANES-1:0][DIG_WIDTH-1:0]           dn_dmag,
   output logic [sit_pkg::LANES-1:0][REM_WIDTH-1:0]           dn_rem,
   output logic [sit_pkg::LANES-1:0][DIG_WIDTH-1:0]           dn_q,
   output logic [sit_pkg::LANES-1:0][BASE_WIDTH-1:0]          dn_base
);
   import sit_pkg::*;

   // multiplier digit consumed by this step, msb first
   localparam int unsigned BIT_POS = DIG_WIDTH - 1 - STEP;

   logic [REM_WIDTH:0]                   two_den;
   logic [REM_WIDTH:0]                   one_den;
   logic [LANES-1:0][REM_WIDTH:0]        partial;
   logic [LANES-1:0][1:0]                digit;
   logic [LANES-1:0][REM_WIDTH-1:0]      rem_in;
   logic [LANES-1:0][DIG_WIDTH-1:0]      q_in;

   sit_flags_type                        flags_ff;
   logic [REM_WIDTH-1:0]                 den_ff;
   logic [REM_WIDTH-1:0]                 na_ff;
   logic [LANES-1:0][DIG_WIDTH-1:0]      dmag_ff;
   logic [LANES-1:0][REM_WIDTH-1:0]      rem_ff;
   logic [LANES-1:0][DIG_WIDTH-1:0]      q_ff;
   logic [LANES-1:0][BASE_WIDTH-1:0]     base_ff;

   assign two_den = {up_den, 1'b0};
   assign one_den = {1'b0, up_den};

   // long division of dmag*na by den: remainder stays below den, so the
   // shifted remainder plus na stays below three times den
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         partial[l] = {up_rem[l], 1'b0}
                    + (up_dmag[l][BIT_POS] ? {1'b0, up_na} : '0);
         priority if (partial[l] >= two_den) begin
            rem_in[l] = REM_WIDTH'(partial[l] - two_den);
            digit[l]  = 2'd2;
         end else if (partial[l] >= one_den) begin
            rem_in[l] = REM_WIDTH'(partial[l] - one_den);
            digit[l]  = 2'd1;
         end else begin
            rem_in[l] = partial[l][REM_WIDTH-1:0];
            digit[l]  = 2'd0;
         end
         q_in[l] = {up_q[l][DIG_WIDTH-2:0], 1'b0} + DIG_WIDTH'(digit[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff <= up_flags;
         den_ff   <= up_den;
         na_ff    <= up_na;
         dmag_ff  <= up_dmag;
         rem_ff   <= rem_in;
         q_ff     <= q_in;
         base_ff  <= up_base;
      end
   end

   assign dn_flags = flags_ff;
   assign dn_den   = den_ff;
   assign dn_na    = na_ff;
   assign dn_dmag  = dmag_ff;
   assign dn_rem   = rem_ff;
   assign dn_q     = q_ff;
   assign dn_base  = base_ff;

endmodule
